// ===== hdl/lru_pkg.sv =====
// shared types and constants for the true-lru age replacement block
// no dependencies; imported by lru_age_replacement
package lru_pkg;

  localparam int unsigned WayW  = 3;
  localparam int unsigned MaskW = 8;
  localparam int unsigned AgeOutW = 3;

  typedef enum logic [0:0] {
    OP_TOUCH  = 1'b0,
    OP_VICTIM = 1'b1
  } op_e;

endpackage

// ===== hdl/lru_age_replacement.sv =====
// true-lru replacement for one cache set, kept as per-way age counters
// depends on lru_pkg for field widths and the opcode enum
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_stall_o | opcode, way, valid_mask, replaceable_mask
//  out     | output    | out_valid_o / out_stall_i | chosen_way, took_invalid,
//          |           |                        | none_replaceable, prior_age
//
// one transaction per cycle unless the output stalls; each passes from
// the input register through compare/select logic to the result register
// the age update is written at the same edge as the result, so the next
// transaction in the input register always sees current ages
// reset puts way i at age i; a stalled output holds the input stage, which
// then stalls the input channel
module lru_age_replacement
  import lru_pkg::*;
#(
  parameter int unsigned WAYS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [0:0]          opcode_i,
  input  logic [WayW-1:0]     way_i,
  input  logic [MaskW-1:0]    valid_mask_i,
  input  logic [MaskW-1:0]    replaceable_mask_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WayW-1:0]     chosen_way_o,
  output logic                took_invalid_o,
  output logic                none_replaceable_o,
  output logic [AgeOutW-1:0]  prior_age_o
);

  localparam int unsigned IdxW = $clog2(WAYS);
  localparam int unsigned AgeW = $clog2(WAYS);
  localparam int unsigned ExtW = (WAYS > MaskW) ? WAYS : MaskW;

  // input stage
  logic             s1_valid_q;
  op_e              op_q;
  logic [WayW-1:0]  way_q;
  logic [MaskW-1:0] vmask_q;
  logic [MaskW-1:0] rmask_q;

  // ages and result stage
  logic [AgeW-1:0]    ages_q [WAYS];
  logic [AgeW-1:0]    ages_d [WAYS];
  logic               out_valid_q;
  logic [WayW-1:0]    chosen_q;
  logic               took_inv_q;
  logic               none_q;
  logic [AgeOutW-1:0] prior_q;

  logic advance;
  logic accept;

  logic [ExtW-1:0] v_ext;
  logic [ExtW-1:0] r_ext;
  logic [WAYS-1:0] inv;
  logic [WAYS-1:0] inv_low;
  logic [WAYS-1:0] repl;
  logic [WAYS-1:0] oldest;
  logic            any_inv;
  logic            any_repl;
  logic            touch_ok;
  logic            upd_en;
  logic [IdxW-1:0] tgt_idx;
  logic [AgeW-1:0] old_age;
  logic            took_inv_d;
  logic            none_d;

  function automatic logic [IdxW-1:0] onehot_idx(input logic [WAYS-1:0] oh);
    logic [IdxW-1:0] r;
    r = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (oh[i]) begin
        r = r | IdxW'(i);
      end
    end
    return r;
  endfunction

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(opcode_i);
      way_q   <= way_i;
      vmask_q <= valid_mask_i;
      rmask_q <= replaceable_mask_i;
    end
  end

  // victim selection; ways above the mask width read as invalid
  always_comb begin
    v_ext    = ExtW'(vmask_q);
    r_ext    = ExtW'(rmask_q);
    inv      = ~v_ext[WAYS-1:0];
    repl     = r_ext[WAYS-1:0];
    inv_low  = inv & (~inv + WAYS'(1));
    any_inv  = |inv;
    any_repl = |repl;
    for (int i = 0; i < WAYS; i++) begin
      oldest[i] = repl[i];
      for (int j = 0; j < WAYS; j++) begin
        if (j != i && repl[j] && !(ages_q[j] < ages_q[i])) begin
          oldest[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    touch_ok   = 32'(way_q) < WAYS;
    took_inv_d = 1'b0;
    none_d     = 1'b0;
    upd_en     = 1'b0;
    tgt_idx    = '0;
    case (op_q)
      OP_TOUCH: begin
        upd_en  = touch_ok;
        tgt_idx = IdxW'(way_q);
      end
      OP_VICTIM: begin
        upd_en = 1'b1;
        if (any_inv) begin
          took_inv_d = 1'b1;
          tgt_idx    = onehot_idx(inv_low);
        end else if (any_repl) begin
          tgt_idx = onehot_idx(oldest);
        end else begin
          none_d = 1'b1;
        end
      end
      default: begin
        upd_en = 1'b0;
      end
    endcase
    old_age = upd_en ? ages_q[tgt_idx] : '0;
    for (int i = 0; i < WAYS; i++) begin
      if (upd_en && IdxW'(i) == tgt_idx) begin
        ages_d[i] = '0;
      end else if (upd_en && ages_q[i] < old_age) begin
        ages_d[i] = ages_q[i] + AgeW'(1);
      end else begin
        ages_d[i] = ages_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WAYS; i++) begin
        ages_q[i] <= AgeW'(i);
      end
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        ages_q      <= ages_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      chosen_q   <= (op_q == OP_TOUCH) ? way_q : WayW'(tgt_idx);
      took_inv_q <= took_inv_d;
      none_q     <= none_d;
      prior_q    <= AgeOutW'(old_age);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign chosen_way_o       = chosen_q;
  assign took_invalid_o     = took_inv_q;
  assign none_replaceable_o = none_q;
  assign prior_age_o        = prior_q;

endmodule
